[design/trd_pkg.sv]
// Package for the touch report decoder: shared types, codes and the report,
// configuration, decode and result structures.
// No dependencies; the decoder, tracker and top level import it.
`timescale 1ns / 1ps

package trd_pkg;

    // Report layout selected by the protocol register.
    localparam logic PROTO_A = 1'b0;
    localparam logic PROTO_B = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PROTOCOL     = 2'd0;
    localparam logic [1:0] CFG_X_LIMIT      = 2'd1;
    localparam logic [1:0] CFG_Y_LIMIT      = 2'd2;
    localparam logic [1:0] CFG_RELEASE_HOLD = 2'd3;

    localparam int CFG_DATA_W = 13;

    // Reset values of the configuration registers.
    localparam logic [12:0] X_LIMIT_RST      = 13'd1024;
    localparam logic [12:0] Y_LIMIT_RST      = 13'd600;
    localparam logic [1:0]  RELEASE_HOLD_RST = 2'd2;

    // Largest panel resolution and the point count limit (valid counts lie below it).
    localparam logic [12:0] LIMIT_MAX   = 13'd4096;
    localparam logic [3:0]  COUNT_LIMIT = 4'd6;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DOWN     = 2'd1,
        PH_RELEASED = 2'd2
    } t_phase;

    typedef struct packed {
        logic       read_ok;
        logic [7:0] status_byte;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [7:0] byte_four;
        logic [7:0] byte_five;
    } t_report;

    typedef struct packed {
        logic        protocol;
        logic [12:0] x_limit;
        logic [12:0] y_limit;
        logic [1:0]  release_hold;
    } t_cfg;

    // What the decoder hands to the touch tracker for one report.
    typedef struct packed {
        logic        drop;    // type B failed read: contact is dropped, nothing else moves
        logic        valid;   // report carries an accepted sample
        logic [3:0]  count;
        logic        ready;
        logic        clear;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
    } t_decoded;

    typedef struct packed {
        logic        touched;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [1:0]  touch_phase;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [3:0]  point_count;
        logic        data_ready;
        logic        clear_status;
        logic [31:0] sample_count;
        logic [31:0] release_count;
    } t_result;

endpackage

[design/trd_report_if.sv]
// Valid/ready channel interfaces for touch reports in and decoded results out.
// Depends on nothing; field names follow the block's report and result lists.
`timescale 1ns / 1ps

interface trd_report_if;
    logic       valid;
    logic       ready;
    logic       read_ok;
    logic [7:0] status_byte;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [7:0] byte_four;
    logic [7:0] byte_five;

    modport source (
        output valid, read_ok, status_byte, byte_one, byte_two, byte_three,
               byte_four, byte_five,
        input  ready
    );
    modport sink (
        input  valid, read_ok, status_byte, byte_one, byte_two, byte_three,
               byte_four, byte_five,
        output ready
    );
endinterface

interface trd_result_if;
    logic        valid;
    logic        ready;
    logic        touched;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [1:0]  touch_phase;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [3:0]  point_count;
    logic        data_ready;
    logic        clear_status;
    logic [31:0] sample_count;
    logic [31:0] release_count;

    modport source (
        output valid, touched, pos_x, pos_y, touch_phase, raw_x, raw_y,
               point_count, data_ready, clear_status, sample_count, release_count,
        input  ready
    );
    modport sink (
        input  valid, touched, pos_x, pos_y, touch_phase, raw_x, raw_y,
               point_count, data_ready, clear_status, sample_count, release_count,
        output ready
    );
endinterface

[design/trd_decode.sv]
// Report decoder: unpacks one report in layout A or B, checks the range and
// clamps the coordinates. Pure combinational logic; depends on trd_pkg.
`timescale 1ns / 1ps

module trd_decode import trd_pkg::*; (
    input  t_report  i_report,
    input  t_cfg     i_cfg,
    output t_decoded o_dec
);

    logic [12:0] x_lim;
    logic [12:0] y_lim;
    logic [12:0] x_top;
    logic [12:0] y_top;
    logic [7:0]  stat;
    logic [7:0]  b1, b2, b3, b4, b5;
    logic [15:0] x_a;
    logic [15:0] y_a;
    logic        out_of_range;
    logic [15:0] x_sel;
    logic [15:0] y_sel;
    logic        count_ok;

    // Zero acts as one and anything above the largest panel acts as 4096.
    always_comb begin
        x_lim = i_cfg.x_limit;
        if (i_cfg.x_limit == 13'd0) begin
            x_lim = 13'd1;
        end else if (i_cfg.x_limit > LIMIT_MAX) begin
            x_lim = LIMIT_MAX;
        end
        y_lim = i_cfg.y_limit;
        if (i_cfg.y_limit == 13'd0) begin
            y_lim = 13'd1;
        end else if (i_cfg.y_limit > LIMIT_MAX) begin
            y_lim = LIMIT_MAX;
        end
    end

    assign x_top = x_lim - 13'd1;
    assign y_top = y_lim - 13'd1;

    // A failed type A read is treated as a report of all zero bytes.
    always_comb begin
        if (i_cfg.protocol == PROTO_A && !i_report.read_ok) begin
            stat = 8'd0;
            b1   = 8'd0;
            b2   = 8'd0;
            b3   = 8'd0;
            b4   = 8'd0;
            b5   = 8'd0;
        end else begin
            stat = i_report.status_byte;
            b1   = i_report.byte_one;
            b2   = i_report.byte_two;
            b3   = i_report.byte_three;
            b4   = i_report.byte_four;
            b5   = i_report.byte_five;
        end
    end

    assign count_ok     = (stat[3:0] != 4'd0) && (stat[3:0] < COUNT_LIMIT);
    assign x_a          = {b2, b1};
    assign y_a          = {b4, b3};
    assign out_of_range = (x_a >= {3'b000, x_lim}) || (y_a >= {3'b000, y_lim});

    always_comb begin
        o_dec.count = stat[3:0];
        o_dec.drop  = 1'b0;
        if (i_cfg.protocol == PROTO_A) begin
            o_dec.ready = stat[7];
            o_dec.clear = stat[7];
            o_dec.valid = stat[7] && count_ok;
            // Out of range points are retried one byte further on.
            if (out_of_range) begin
                x_sel = {b3, b2};
                y_sel = {b5, b4};
            end else begin
                x_sel = x_a;
                y_sel = y_a;
            end
        end else begin
            o_dec.drop  = !i_report.read_ok;
            o_dec.ready = (stat[3:0] != 4'd0);
            o_dec.clear = 1'b0;
            o_dec.valid = i_report.read_ok && count_ok;
            x_sel       = {4'h0, b1[3:0], b2};
            y_sel       = {4'h0, b3[3:0], b4};
        end
        o_dec.raw_x = x_sel;
        o_dec.raw_y = y_sel;
        o_dec.pos_x = (x_sel > {3'b000, x_top}) ? x_top[11:0] : x_sel[11:0];
        o_dec.pos_y = (y_sel > {3'b000, y_top}) ? y_top[11:0] : y_sel[11:0];
    end

endmodule

[design/trd_track.sv]
// Touch tracker: holds the last sample, the contact phase, the release filter
// and the counters, and forms the result for each decoded report. Uses trd_pkg.
`timescale 1ns / 1ps

module trd_track import trd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_advance,
    input  logic [1:0] i_release_hold,
    input  t_decoded i_dec,
    output t_result  o_result
);

    t_phase      r_phase,   n_phase;
    logic [1:0]  r_filter,  n_filter;
    logic [11:0] r_held_x,  n_held_x;
    logic [11:0] r_held_y,  n_held_y;
    logic [15:0] r_raw_x,   n_raw_x;
    logic [15:0] r_raw_y,   n_raw_y;
    logic [3:0]  r_count,   n_count;
    logic        r_ready,   n_ready;
    logic [31:0] r_samples, n_samples;
    logic [31:0] r_releases, n_releases;
    logic        n_touched;

    always_comb begin
        n_phase    = r_phase;
        n_filter   = r_filter;
        n_held_x   = r_held_x;
        n_held_y   = r_held_y;
        n_raw_x    = r_raw_x;
        n_raw_y    = r_raw_y;
        n_count    = r_count;
        n_ready    = r_ready;
        n_samples  = r_samples;
        n_releases = r_releases;
        n_touched  = 1'b0;
        if (i_dec.drop) begin
            n_phase = PH_IDLE;
        end else begin
            n_count = i_dec.count;
            n_ready = i_dec.ready;
            if (i_dec.valid) begin
                n_raw_x   = i_dec.raw_x;
                n_raw_y   = i_dec.raw_y;
                n_held_x  = i_dec.pos_x;
                n_held_y  = i_dec.pos_y;
                n_phase   = PH_DOWN;
                n_filter  = 2'd0;
                n_samples = r_samples + 32'd1;
                n_touched = 1'b1;
            end else if (r_phase == PH_DOWN) begin
                // Empty poll while down: hold the contact for release_hold polls first.
                if (r_filter < i_release_hold) begin
                    n_filter  = r_filter + 2'd1;
                    n_touched = 1'b1;
                end else begin
                    n_phase    = PH_RELEASED;
                    n_releases = r_releases + 32'd1;
                end
            end else begin
                n_phase = PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_filter   <= 2'd0;
            r_held_x   <= 12'd0;
            r_held_y   <= 12'd0;
            r_raw_x    <= 16'd0;
            r_raw_y    <= 16'd0;
            r_count    <= 4'd0;
            r_ready    <= 1'b0;
            r_samples  <= 32'd0;
            r_releases <= 32'd0;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_filter   <= n_filter;
            r_held_x   <= n_held_x;
            r_held_y   <= n_held_y;
            r_raw_x    <= n_raw_x;
            r_raw_y    <= n_raw_y;
            r_count    <= n_count;
            r_ready    <= n_ready;
            r_samples  <= n_samples;
            r_releases <= n_releases;
        end
    end

    assign o_result.touched       = n_touched;
    assign o_result.pos_x         = n_held_x;
    assign o_result.pos_y         = n_held_y;
    assign o_result.touch_phase   = n_phase;
    assign o_result.raw_x         = n_raw_x;
    assign o_result.raw_y         = n_raw_y;
    assign o_result.point_count   = n_count;
    assign o_result.data_ready    = n_ready;
    assign o_result.clear_status  = i_dec.clear;
    assign o_result.sample_count  = n_samples;
    assign o_result.release_count = n_releases;

endmodule

[design/touch_report_decoder.sv]
// Top level of the touch report decoder: configuration registers, input
// register, decoder, touch tracker and result register. Uses trd_pkg,
// trd_report_if, trd_result_if, trd_decode and trd_track.
`timescale 1ns / 1ps

// The decoder takes one polled touch report per transfer on i_report and
// returns exactly one result per report on o_result, in order. A report is
// captured in an input register, decoded and folded into the touch state once
// the result register can take it, and the result lands in an output
// register, so one report can be taken in every cycle while o_result does
// not stall. The decode, clamp and filter logic lies between the input
// and result registers; the input register frees
// itself whenever the result register is empty or being drained. A result
// that waits on a stalled o_result keeps the held report in the input
// register, and i_report then stalls until the result is taken. Configuration
// (protocol, x_limit, y_limit, release_hold at indexes 0 to 3) is written
// through i_cfg_we/i_cfg_idx/i_cfg_data and must only change while no report
// is in flight. There is no clearing pass after reset.
module touch_report_decoder import trd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    trd_report_if.sink            i_report,
    trd_result_if.source          o_result
);

    t_cfg     r_cfg;
    t_report  r_in;
    logic     r_in_valid;
    t_result  r_out;
    logic     r_out_valid;
    t_report  in_payload;
    t_decoded dec;
    t_result  n_result;
    logic     accept;
    logic     advance;

    // Configuration registers; every write lands at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.protocol     <= PROTO_A;
            r_cfg.x_limit      <= X_LIMIT_RST;
            r_cfg.y_limit      <= Y_LIMIT_RST;
            r_cfg.release_hold <= RELEASE_HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROTOCOL:     r_cfg.protocol     <= i_cfg_data[0];
                CFG_X_LIMIT:      r_cfg.x_limit      <= i_cfg_data;
                CFG_Y_LIMIT:      r_cfg.y_limit      <= i_cfg_data;
                CFG_RELEASE_HOLD: r_cfg.release_hold <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign in_payload.read_ok     = i_report.read_ok;
    assign in_payload.status_byte = i_report.status_byte;
    assign in_payload.byte_one    = i_report.byte_one;
    assign in_payload.byte_two    = i_report.byte_two;
    assign in_payload.byte_three  = i_report.byte_three;
    assign in_payload.byte_four   = i_report.byte_four;
    assign in_payload.byte_five   = i_report.byte_five;

    // A held report moves on when the result register is empty or is being
    // drained in this cycle; the input register then takes the next transfer.
    assign advance         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_report.ready  = !r_in_valid || advance;
    assign accept          = i_report.valid && i_report.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= in_payload;
        end
    end

    trd_decode u_decode (
        .i_report (r_in),
        .i_cfg    (r_cfg),
        .o_dec    (dec)
    );

    // The tracker commits its state only when the result is captured.
    trd_track u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_release_hold (r_cfg.release_hold),
        .i_dec          (dec),
        .o_result       (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.touched       = r_out.touched;
    assign o_result.pos_x         = r_out.pos_x;
    assign o_result.pos_y         = r_out.pos_y;
    assign o_result.touch_phase   = r_out.touch_phase;
    assign o_result.raw_x         = r_out.raw_x;
    assign o_result.raw_y         = r_out.raw_y;
    assign o_result.point_count   = r_out.point_count;
    assign o_result.data_ready    = r_out.data_ready;
    assign o_result.clear_status  = r_out.clear_status;
    assign o_result.sample_count  = r_out.sample_count;
    assign o_result.release_count = r_out.release_count;

endmodule
